FILE: rtl/core/vn_pkg.sv
// Shared types, constants and per-stage step functions for the vector normalizer.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package vn_pkg;

    localparam int COMP_W    = 16;
    localparam int DIV_STEPS = 29;   // quotient bits of c*c*2^28 / S
    localparam int USQ_STEPS = 15;   // root bits of the unit square root
    localparam int MAG_STEPS = 16;   // root bits of the magnitude

    typedef struct packed {
        logic [2:0][30:0] sq;
        logic [31:0]      sum;
        logic [2:0]       neg;
        logic             zero;
    } vn_front_t;

    typedef struct packed {
        logic [31:0]      den;
        logic [2:0][31:0] rem;
        logic [2:0]       nbit;
        logic [2:0][28:0] quo;
        logic [2:0]       neg;
        logic             zero;
        logic [31:0]      mval;
        logic [17:0]      mrem;
        logic [15:0]      mroot;
    } vn_div_t;

    typedef struct packed {
        logic [2:0][29:0] val;
        logic [2:0][16:0] rem;
        logic [2:0][14:0] root;
        logic [2:0]       neg;
        logic             zero;
        logic [15:0]      mag;
    } vn_usq_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_unit;
        logic signed [COMP_W-1:0] y_unit;
        logic signed [COMP_W-1:0] z_unit;
        logic [COMP_W-1:0]        magnitude;
        logic                     is_zero;
    } vn_res_t;

    // One restoring division bit on all lanes, plus one magnitude root bit when mag_on is set
    function automatic vn_div_t div_step(input vn_div_t d, input logic mag_on);
        vn_div_t     n;
        logic [32:0] t;
        logic [17:0] mr2;
        logic [17:0] mtr;
        n = d;
        for (int i = 0; i < 3; i++) begin
            t = {d.rem[i], d.nbit[i]};
            if (t >= {1'b0, d.den}) begin
                n.rem[i] = 32'(t - {1'b0, d.den});
                n.quo[i] = {d.quo[i][27:0], 1'b1};
            end else begin
                n.rem[i] = t[31:0];
                n.quo[i] = {d.quo[i][27:0], 1'b0};
            end
            n.nbit[i] = 1'b0;
        end
        if (mag_on) begin
            mr2 = {d.mrem[15:0], d.mval[31:30]};
            mtr = {d.mroot, 2'b01};
            if (mr2 >= mtr) begin
                n.mrem  = mr2 - mtr;
                n.mroot = {d.mroot[14:0], 1'b1};
            end else begin
                n.mrem  = mr2;
                n.mroot = {d.mroot[14:0], 1'b0};
            end
            n.mval = {d.mval[29:0], 2'b00};
        end
        return n;
    endfunction

    // One square-root bit on all three unit lanes
    function automatic vn_usq_t usq_step(input vn_usq_t u);
        vn_usq_t     n;
        logic [16:0] r2;
        logic [16:0] tr;
        n = u;
        for (int i = 0; i < 3; i++) begin
            r2 = {u.rem[i][14:0], u.val[i][29:28]};
            tr = {u.root[i], 2'b01};
            if (r2 >= tr) begin
                n.rem[i]  = r2 - tr;
                n.root[i] = {u.root[i][13:0], 1'b1};
            end else begin
                n.rem[i]  = r2;
                n.root[i] = {u.root[i][13:0], 1'b0};
            end
            n.val[i] = {u.val[i][27:0], 2'b00};
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/vn_if.sv
// Request channel interfaces for input vectors and normalized results.
// Depends on vn_pkg for the component width.
`timescale 1ns / 1ps

interface vn_in_if;
    import vn_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] x_in;
    logic signed [COMP_W-1:0] y_in;
    logic signed [COMP_W-1:0] z_in;
    modport source (output valid, x_in, y_in, z_in, input ready);
    modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vn_out_if;
    import vn_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] x_unit;
    logic signed [COMP_W-1:0] y_unit;
    logic signed [COMP_W-1:0] z_unit;
    logic [COMP_W-1:0]        magnitude;
    logic                     is_zero;
    modport source (output valid, x_unit, y_unit, z_unit, magnitude, is_zero, input ready);
    modport sink   (input valid, x_unit, y_unit, z_unit, magnitude, is_zero, output ready);
endinterface

FILE: rtl/core/vn_front.sv
// Front end: absolute values, squares and sum of squares over three stages.
// Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_front
    import vn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [COMP_W-1:0] x_in,
    input  logic signed [COMP_W-1:0] y_in,
    input  logic signed [COMP_W-1:0] z_in,
    output logic                     out_valid,
    output vn_front_t                out_data
);

    logic [2:0][15:0] abs_reg;
    logic [2:0]       neg_a_reg;
    logic [2:0][30:0] sq_reg;
    logic [2:0]       neg_b_reg;
    vn_front_t        front_reg;
    logic [2:0]       vld_reg;
    logic [2:0][15:0] raw;

    assign raw = {z_in, y_in, x_in};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Advance payload: magnitude, squares, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_a_reg[i] <= raw[i][15];
                abs_reg[i]   <= raw[i][15] ? 16'(~raw[i] + 16'd1) : raw[i];
                sq_reg[i]    <= 31'(32'(abs_reg[i]) * 32'(abs_reg[i]));
            end
            neg_b_reg      <= neg_a_reg;
            front_reg.sq   <= sq_reg;
            front_reg.neg  <= neg_b_reg;
            front_reg.sum  <= 32'(sq_reg[0]) + 32'(sq_reg[1]) + 32'(sq_reg[2]);
            front_reg.zero <= (sq_reg[0] == '0) && (sq_reg[1] == '0) && (sq_reg[2] == '0);
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = front_reg;

endmodule

FILE: rtl/core/vn_div.sv
// Divider pipeline: one quotient bit per stage on three lanes, with the
// magnitude square root riding along in the first MAG_STEPS stages. Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_div
    import vn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  vn_front_t in_data,
    output logic      out_valid,
    output vn_div_t   out_data
);

    vn_div_t                stg_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0]   vld_reg;
    vn_div_t                init;

    // Seed remainders with the dividend bits above the quotient
    always_comb
    begin
        init       = '0;
        init.den   = in_data.sum;
        init.neg   = in_data.neg;
        init.zero  = in_data.zero;
        init.mval  = in_data.sum;
        for (int i = 0; i < 3; i++)
        begin
            init.rem[i]  = {2'b00, in_data.sq[i][30:1]};
            init.nbit[i] = in_data.sq[i][0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_stage
        localparam logic MAG_ON = (k < MAG_STEPS);
        vn_div_t src;
        if (k == 0)
        begin : g_first
            assign src = init;
        end
        else
        begin : g_rest
            assign src = stg_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k] <= div_step(src, MAG_ON);
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_data  = stg_reg[DIV_STEPS-1];

endmodule

FILE: rtl/core/vn_usq.sv
// Unit square-root pipeline, one root bit per stage, then sign and zero
// handling into the result register. Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_usq
    import vn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  vn_div_t in_data,
    output logic    out_valid,
    output vn_res_t out_data
);

    vn_usq_t              stg_reg [USQ_STEPS];
    logic [USQ_STEPS:0]   vld_reg;
    vn_usq_t              init;
    vn_usq_t              last;
    vn_res_t              res_reg;
    logic [2:0][15:0]     unit;

    always_comb
    begin
        init      = '0;
        init.neg  = in_data.neg;
        init.zero = in_data.zero;
        init.mag  = in_data.mroot;
        for (int i = 0; i < 3; i++)
        begin
            init.val[i] = {1'b0, in_data.quo[i]};
        end
    end

    // Advance valid bits, result stage included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[USQ_STEPS-1:0], in_valid};
        end
    end

    for (genvar k = 0; k < USQ_STEPS; k++)
    begin : g_stage
        vn_usq_t src;
        if (k == 0)
        begin : g_first
            assign src = init;
        end
        else
        begin : g_rest
            assign src = stg_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k] <= usq_step(src);
            end
        end
    end

    // Apply sign, force zero vector results
    assign last = stg_reg[USQ_STEPS-1];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (last.zero)
                unit[i] = '0;
            else if (last.neg[i])
                unit[i] = 16'(~{1'b0, last.root[i]} + 16'd1);
            else
                unit[i] = {1'b0, last.root[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.x_unit    <= unit[0];
            res_reg.y_unit    <= unit[1];
            res_reg.z_unit    <= unit[2];
            res_reg.magnitude <= last.zero ? '0 : last.mag;
            res_reg.is_zero   <= last.zero;
        end
    end

    assign out_valid = vld_reg[USQ_STEPS];
    assign out_data  = res_reg;

endmodule

FILE: rtl/core/vector3_normalize.sv
// Pipeline: 3 front stages, 29 divider stages, 15 root stages and 1 result
// register lie between request accept and result valid.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits, set by the single shared enable from the output register.
// Reset: rst_n asynchronous active low clears all valid bits; payload is not reset.
// Depends on vn_pkg, vn_if, vn_front, vn_div, vn_usq.
`timescale 1ns / 1ps

module vector3_normalize
    import vn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    vn_in_if.sink    in_ch,
    vn_out_if.source out_ch
);

    logic      en;
    logic      f_valid;
    vn_front_t f_data;
    logic      d_valid;
    vn_div_t   d_data;
    logic      r_valid;
    vn_res_t   r_data;

    // Advance when the output slot is empty or being taken
    assign en          = !r_valid || out_ch.ready;
    assign in_ch.ready = en;

    vn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .x_in      (in_ch.x_in),
        .y_in      (in_ch.y_in),
        .z_in      (in_ch.z_in),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    vn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    vn_usq u_usq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_data   (d_data),
        .out_valid (r_valid),
        .out_data  (r_data)
    );

    assign out_ch.valid     = r_valid;
    assign out_ch.x_unit    = r_data.x_unit;
    assign out_ch.y_unit    = r_data.y_unit;
    assign out_ch.z_unit    = r_data.z_unit;
    assign out_ch.magnitude = r_data.magnitude;
    assign out_ch.is_zero   = r_data.is_zero;

`ifndef SYNTHESIS
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && r_data.is_zero) |-> (r_data.x_unit == 0 && r_data.y_unit == 0
            && r_data.z_unit == 0 && r_data.magnitude == 0))
        else $error("zero vector result not cleared");
    a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_data.is_zero) |-> (r_data.magnitude != 0))
        else $error("nonzero vector with zero magnitude");
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (r_data.x_unit <= 16384 && r_data.x_unit >= -16384
            && r_data.y_unit <= 16384 && r_data.y_unit >= -16384
            && r_data.z_unit <= 16384 && r_data.z_unit >= -16384))
        else $error("unit component out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !out_ch.ready) |=> (r_valid && $stable(r_data)))
        else $error("stalled result changed");
`endif

endmodule
